FILE: src/surplus_power_load_dispatcher_core_assert.svh
// assertion macros for the load dispatcher
`ifndef SURPLUS_POWER_LOAD_DISPATCHER_CORE_ASSERT_SVH
`define SURPLUS_POWER_LOAD_DISPATCHER_CORE_ASSERT_SVH

// clocked check, off while reset is asserted
`define SPLD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define SPLD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/spld_pkg.sv
package spld_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM,
		ST_GRANT,
		ST_APPLY,
		ST_DONE
	} state_t;

	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_MANUAL = 2'd1;
	localparam logic [1:0] FUNC_MODE   = 2'd2;

	localparam logic [2:0] REG_POWERS     = 3'd0;
	localparam logic [2:0] REG_PRIORITIES = 3'd1;
	localparam logic [2:0] REG_ACTIVE     = 3'd2;
	localparam logic [2:0] REG_RESERVE    = 3'd3;
	localparam logic [2:0] REG_HYSTERESIS = 3'd4;
	localparam logic [2:0] REG_MIN_TOGGLE = 3'd5;
	localparam logic [2:0] REG_ACTIVE_LOW = 3'd6;

	// signed working width of the surplus: 16-bit terms, up to four load powers added
	localparam int REM_BITS = 21;

	typedef logic signed [REM_BITS-1:0] rem_t;

endpackage

FILE: src/surplus_power_load_dispatcher_core.sv
// surplus power load dispatcher
// switches up to LOADS relay loads on spare solar power
// request channel (in_valid/in_ready): func selects a periodic tick, a manual
// relay set or a mode set; every request yields exactly one response
// response channel (out_valid/out_ready): on mask, pin levels, accepted flag
// and the auto mode flag, held in an output register until taken
// config channel (cfg_valid/cfg_ready): always ready, register index and data;
// writes are meant to happen while no request is in flight
// last toggle times live in a small one-port synchronous memory; an auto tick
// reads every entry once, forms the surplus, grants one load per cycle in
// priority order and writes back the toggled entries; other requests go
// straight to the write-back of the toggled entries
// one request is in work at a time; in_ready rises again once the response is
// in the output register, so a stalled receiver holds one response there, one
// more request is taken and waits in ST_DONE, and then new requests are blocked
// reset clears all loads to off, manual mode, all config registers to zero and the
// toggle times to zero (never toggled)
module surplus_power_load_dispatcher_core #(
	parameter int LOADS     = 4,
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic        telemetry_ok,
	input  logic [15:0] pv_power_w,
	input  logic [15:0] site_load_w,
	input  logic [31:0] now_ms,
	input  logic [1:0]  relay_index,
	input  logic        relay_enable,
	input  logic        mode_auto,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  relay_on_mask,
	output logic [3:0]  relay_pin_levels,
	output logic        accepted,
	output logic        auto_active,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int LIDX = (LOADS > 1) ? $clog2(LOADS) : 1;
	localparam int CW   = $clog2(LOADS + 1);
	localparam int RB   = spld_pkg::REM_BITS;

	// configuration registers
	logic [63:0] powers_q;
	logic [31:0] prios_q;
	logic [3:0]  active_q;
	logic [15:0] reserve_q;
	logic [15:0] hyst_q;
	logic [31:0] min_toggle_q;
	logic        active_low_q;

	// request latched at acceptance
	logic [15:0]          pv_q;
	logic [15:0]          site_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 acc_q;

	// load state and tick scratch
	logic [LOADS-1:0] on_q;
	logic             auto_q;
	logic [LOADS-1:0] may_q;
	logic [LOADS-1:0] want_q;
	logic [LOADS-1:0] done_q;
	logic [LOADS-1:0] newon_q;
	spld_pkg::rem_t   rem_q;
	logic [CW-1:0]    cnt_q;

	spld_pkg::state_t state_q, state_d;

	// toggle time memory
	logic [TIME_BITS-1:0] time_mem [LOADS];
	logic [TIME_BITS-1:0] rd_data_q;
	logic                 mem_rd;
	logic                 mem_we;
	logic                 out_load;

	// output register
	logic       out_valid_q;
	logic [3:0] mask_q;
	logic [3:0] pins_q;
	logic       acc_out_q;
	logic       auto_out_q;

	logic in_acc;
	logic slot_free;
	logic auto_tick_req;

	logic [LOADS-1:0]     in_order;
	logic [LOADS-1:0]     elig;
	logic                 pick_found;
	logic [LIDX-1:0]      pick;
	logic [7:0]           pick_prio;
	spld_pkg::rem_t       pick_pw;
	spld_pkg::rem_t       pick_need;
	spld_pkg::rem_t       rem_init;
	logic [LOADS-1:0]     auto_newon;
	logic [LOADS-1:0]     req_newon;
	logic                 req_acc;
	logic                 may_now;
	logic [TIME_BITS-1:0] age;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign auto_tick_req = (func == spld_pkg::FUNC_TICK) && telemetry_ok && auto_q;

	// config writes, unused index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			powers_q     <= '0;
			prios_q      <= '0;
			active_q     <= '0;
			reserve_q    <= '0;
			hyst_q       <= '0;
			min_toggle_q <= '0;
			active_low_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				spld_pkg::REG_POWERS:     powers_q     <= cfg_data;
				spld_pkg::REG_PRIORITIES: prios_q      <= cfg_data[31:0];
				spld_pkg::REG_ACTIVE:     active_q     <= cfg_data[3:0];
				spld_pkg::REG_RESERVE:    reserve_q    <= cfg_data[15:0];
				spld_pkg::REG_HYSTERESIS: hyst_q       <= cfg_data[15:0];
				spld_pkg::REG_MIN_TOGGLE: min_toggle_q <= cfg_data[31:0];
				spld_pkg::REG_ACTIVE_LOW: active_low_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// loads that take part in the auto grant: active with nonzero rating
	always_comb begin
		for (int i = 0; i < LOADS; i++) begin
			in_order[i] = active_q[i] && (powers_q[16*i +: 16] != 16'd0);
		end
	end

	// effect of a request that needs no tick walk
	always_comb begin
		req_newon = on_q;
		req_acc   = 1'b1;
		case (func)
			spld_pkg::FUNC_TICK: begin
				if (!telemetry_ok) req_newon = '0;
			end
			spld_pkg::FUNC_MANUAL: begin
				if (auto_q || ({1'b0, relay_index} >= 3'(LOADS))
						|| !active_q[relay_index]) begin
					req_acc = 1'b0;
				end else begin
					for (int i = 0; i < LOADS; i++) begin
						if (relay_index == 2'(i)) req_newon[i] = relay_enable;
					end
				end
			end
			spld_pkg::FUNC_MODE: begin
				if (mode_auto) req_newon = '0;
			end
			default: ;
		endcase
	end

	// toggle check on the entry just read, elapsed time wraps at TIME_BITS
	assign age     = now_q - rd_data_q;
	assign may_now = (rd_data_q == '0) || (32'(age) >= min_toggle_q);

	// starting surplus: held-on loads already subtracted
	always_comb begin
		rem_init = RB'($signed({1'b0, pv_q})) - RB'($signed({1'b0, site_q}))
			- RB'($signed({1'b0, reserve_q}));
		for (int i = 0; i < LOADS; i++) begin
			if (on_q[i]) rem_init = rem_init + RB'($signed({1'b0, powers_q[16*i +: 16]}));
			if (on_q[i] && in_order[i] && !may_q[i]) begin
				rem_init = rem_init - RB'($signed({1'b0, powers_q[16*i +: 16]}));
			end
		end
	end

	// next load in priority order, lower index wins ties
	always_comb begin
		elig       = in_order & ~done_q;
		pick_found = 1'b0;
		pick       = '0;
		pick_prio  = '0;
		for (int i = 0; i < LOADS; i++) begin
			if (elig[i] && (!pick_found || prios_q[8*i +: 8] < pick_prio)) begin
				pick_found = 1'b1;
				pick       = LIDX'(i);
				pick_prio  = prios_q[8*i +: 8];
			end
		end
		pick_pw   = RB'($signed({1'b0, powers_q[16*pick +: 16]}));
		pick_need = on_q[pick] ? pick_pw : pick_pw + RB'($signed({1'b0, hyst_q}));
	end

	// final auto state: change only where a load may toggle; inactive or zero-power loads off
	always_comb begin
		for (int i = 0; i < LOADS; i++) begin
			if (in_order[i]) auto_newon[i] = may_q[i] ? want_q[i] : on_q[i];
			else             auto_newon[i] = 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			spld_pkg::ST_IDLE: begin
				if (in_acc) state_d = auto_tick_req ? spld_pkg::ST_READ : spld_pkg::ST_APPLY;
			end
			spld_pkg::ST_READ: begin
				if (cnt_q == CW'(LOADS)) state_d = spld_pkg::ST_SUM;
			end
			spld_pkg::ST_SUM:   state_d = spld_pkg::ST_GRANT;
			spld_pkg::ST_GRANT: begin
				if (!pick_found) state_d = spld_pkg::ST_APPLY;
			end
			spld_pkg::ST_APPLY: begin
				if (cnt_q == CW'(LOADS - 1)) state_d = spld_pkg::ST_DONE;
			end
			spld_pkg::ST_DONE: begin
				if (slot_free) state_d = spld_pkg::ST_IDLE;
			end
			default: state_d = spld_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		mem_rd   = 1'b0;
		mem_we   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			spld_pkg::ST_IDLE:  in_ready = 1'b1;
			spld_pkg::ST_READ:  mem_rd   = (cnt_q < CW'(LOADS));
			spld_pkg::ST_APPLY: mem_we   = newon_q[cnt_q[LIDX-1:0]] != on_q[cnt_q[LIDX-1:0]];
			spld_pkg::ST_DONE:  out_load = slot_free;
			default: ;
		endcase
	end

	// sequencing and load state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spld_pkg::ST_IDLE;
			cnt_q   <= '0;
			on_q    <= '0;
			auto_q  <= 1'b0;
			may_q   <= '0;
			want_q  <= '0;
			done_q  <= '0;
			newon_q <= '0;
			acc_q   <= 1'b1;
		end else begin
			state_q <= state_d;
			case (state_q)
				spld_pkg::ST_IDLE: begin
					cnt_q  <= '0;
					want_q <= '0;
					done_q <= '0;
					if (in_acc) begin
						newon_q <= req_newon;
						acc_q   <= req_acc;
						if (func == spld_pkg::FUNC_MODE) auto_q <= mode_auto;
					end
				end
				spld_pkg::ST_READ: begin
					if (cnt_q != '0) may_q[LIDX'(cnt_q - CW'(1))] <= may_now;
					cnt_q <= (cnt_q == CW'(LOADS)) ? '0 : cnt_q + CW'(1);
				end
				spld_pkg::ST_GRANT: begin
					if (pick_found) begin
						done_q[pick] <= 1'b1;
						if (on_q[pick] && !may_q[pick]) begin
							want_q[pick] <= 1'b1;
						end else if (rem_q >= pick_need) begin
							want_q[pick] <= 1'b1;
						end
					end else begin
						newon_q <= auto_newon;
					end
				end
				spld_pkg::ST_APPLY: begin
					if (cnt_q == CW'(LOADS - 1)) begin
						cnt_q <= '0;
						on_q  <= newon_q;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// surplus accumulator
	always_ff @(posedge clk) begin
		if (state_q == spld_pkg::ST_SUM) begin
			rem_q <= rem_init;
		end else if (state_q == spld_pkg::ST_GRANT && pick_found
				&& !(on_q[pick] && !may_q[pick]) && rem_q >= pick_need) begin
			rem_q <= rem_q - pick_pw;
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pv_q   <= pv_power_w;
			site_q <= site_load_w;
			now_q  <= now_ms[TIME_BITS-1:0];
		end
	end

	// toggle time memory, zero at reset means never toggled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOADS; i++) time_mem[i] <= '0;
		end else if (mem_we) begin
			time_mem[cnt_q[LIDX-1:0]] <= now_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_rd) rd_data_q <= time_mem[cnt_q[LIDX-1:0]];
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mask_q     <= 4'(on_q);
			pins_q     <= 4'(on_q ^ {LOADS{active_low_q}});
			acc_out_q  <= acc_q;
			auto_out_q <= auto_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign relay_on_mask    = mask_q;
	assign relay_pin_levels = pins_q;
	assign accepted         = acc_out_q;
	assign auto_active      = auto_out_q;

`include "surplus_power_load_dispatcher_core_assert.svh"

	// a taken request always starts work
	`SPLD_ASSERT(a_req_starts, in_valid && in_ready |=> state_q != spld_pkg::ST_IDLE, "request not started")
	// auto mode only drops on a mode set request
	`SPLD_ASSERT(a_auto_drop, $fell(auto_q) |-> $past(in_acc && func == spld_pkg::FUNC_MODE), "auto mode lost")
	// memory writes only during write-back
	`SPLD_ASSERT_ALWAYS(a_we_apply, mem_we |-> state_q == spld_pkg::ST_APPLY, "stray memory write")

endmodule

FILE: sim/surplus_power_load_dispatcher_core_tb.sv
`timescale 1ns / 1ps

module surplus_power_load_dispatcher_core_tb;

	// codes the package leaves unnamed
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [2:0] REG_UNUSED  = 3'd7;
	localparam int NLOADS = 4;
	// response latency of the longest request plus margin
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [3:0] on_mask;
		logic [3:0] pins;
		logic       acc;
		logic       auto_on;
	} relay_state_t;

	typedef struct {
		logic [1:0]   fn;
		logic         tel;
		logic [15:0]  pv;
		logic [15:0]  site;
		logic [31:0]  now;
		logic [1:0]   idx;
		logic         en;
		logic         mauto;
		bit           typed;
		relay_state_t want;
	} request_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic        telemetry_ok;
	logic [15:0] pv_power_w;
	logic [15:0] site_load_w;
	logic [31:0] now_ms;
	logic [1:0]  relay_index;
	logic        relay_enable;
	logic        mode_auto;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  relay_on_mask;
	logic [3:0]  relay_pin_levels;
	logic        accepted;
	logic        auto_active;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	surplus_power_load_dispatcher_core dut (.*);

	// shadow copy of the configuration registers
	logic [63:0] sh_powers;
	logic [31:0] sh_prio;
	logic [3:0]  sh_active;
	logic [15:0] sh_reserve;
	logic [15:0] sh_hyst;
	logic [31:0] sh_min_toggle;
	logic        sh_active_low;

	// shadow copy of the load state
	logic        sh_on [NLOADS];
	logic [31:0] sh_last [NLOADS];
	logic        sh_auto;

	relay_state_t relay_expect_q[$];
	request_row_t directed_rows[$];

	int errors = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int rcv_hold_left = 0;
	logic [31:0] clock_ms;

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic [15:0] load_w(int i);
		return sh_powers[16*i +: 16];
	endfunction

	function automatic logic [7:0] load_prio(int i);
		return sh_prio[8*i +: 8];
	endfunction

	// zero stored time means the load never switched, so it is free to switch
	function automatic bit toggle_free(int i, logic [31:0] now);
		logic [31:0] dt;
		dt = now - sh_last[i];
		return sh_last[i] == 32'd0 || dt >= sh_min_toggle;
	endfunction

	function automatic void switch_load(int i, logic on, logic [31:0] now);
		if (sh_on[i] != on) sh_last[i] = now;
		sh_on[i] = on;
	endfunction

	// greedy grant over the active loads in priority order
	function automatic void dispatch_surplus(logic [15:0] pv, logic [15:0] site,
			logic [31:0] now);
		longint rem;
		longint need;
		int order [NLOADS];
		bit held [NLOADS];
		bit grant [NLOADS];
		int n;
		int b;
		int c;
		int p;
		int i;
		n = 0;
		rem = longint'(pv) - longint'(site) - longint'(sh_reserve);
		for (int k = 0; k < NLOADS; k++) begin
			if (sh_on[k]) rem += load_w(k);
			held[k] = 0;
			grant[k] = 0;
			if (sh_active[k] && load_w(k) != 0) begin
				order[n] = k;
				n++;
			end
		end
		// insertion sort, ties go to the lower index
		for (int a = 1; a < n; a++) begin
			c = order[a];
			b = a;
			while (b > 0) begin
				p = order[b-1];
				if (!(load_prio(p) > load_prio(c) ||
						(load_prio(p) == load_prio(c) && p > c))) break;
				order[b] = p;
				b--;
			end
			order[b] = c;
		end
		// loads inside the minimum toggle time keep their power
		for (int a = 0; a < n; a++) begin
			i = order[a];
			if (sh_on[i] && !toggle_free(i, now)) begin
				held[i] = 1;
				rem -= load_w(i);
			end
		end
		for (int a = 0; a < n; a++) begin
			i = order[a];
			if (held[i]) begin
				grant[i] = 1;
			end else begin
				need = longint'(load_w(i)) + (sh_on[i] ? 0 : longint'(sh_hyst));
				if (rem >= need) begin
					grant[i] = 1;
					rem -= load_w(i);
				end
			end
		end
		for (int a = 0; a < n; a++) begin
			i = order[a];
			if (grant[i] != sh_on[i] && toggle_free(i, now)) switch_load(i, grant[i], now);
		end
		for (int k = 0; k < NLOADS; k++)
			if ((!sh_active[k] || load_w(k) == 0) && sh_on[k]) switch_load(k, 1'b0, now);
	endfunction

	function automatic relay_state_t predict_relays(request_row_t r);
		relay_state_t res;
		res.acc = 1'b1;
		case (r.fn)
			spld_pkg::FUNC_TICK: begin
				if (!r.tel) begin
					for (int k = 0; k < NLOADS; k++) switch_load(k, 1'b0, r.now);
				end else if (sh_auto) begin
					dispatch_surplus(r.pv, r.site, r.now);
				end
			end
			spld_pkg::FUNC_MANUAL: begin
				if (sh_auto || !sh_active[r.idx]) res.acc = 1'b0;
				else switch_load(r.idx, r.en, r.now);
			end
			spld_pkg::FUNC_MODE: begin
				sh_auto = r.mauto;
				if (sh_auto)
					for (int k = 0; k < NLOADS; k++) switch_load(k, 1'b0, r.now);
			end
			default: ;
		endcase
		for (int k = 0; k < NLOADS; k++) res.on_mask[k] = sh_on[k];
		res.pins = res.on_mask ^ {4{sh_active_low}};
		res.auto_on = sh_auto;
		return res;
	endfunction

	// response checker, oldest expectation first
	always @(posedge clk) begin
		relay_state_t e;
		if (arst_n && out_valid && out_ready) begin
			if (relay_expect_q.size() == 0) begin
				$error("response with no request pending");
				errors++;
			end else begin
				e = relay_expect_q.pop_front();
				if (relay_on_mask !== e.on_mask) begin
					$error("relay_on_mask expected %h actual %h", e.on_mask, relay_on_mask);
					errors++;
				end
				if (relay_pin_levels !== e.pins) begin
					$error("relay_pin_levels expected %h actual %h", e.pins, relay_pin_levels);
					errors++;
				end
				if (accepted !== e.acc) begin
					$error("accepted expected %b actual %b", e.acc, accepted);
					errors++;
				end
				if (auto_active !== e.auto_on) begin
					$error("auto_active expected %b actual %b", e.auto_on, auto_active);
					errors++;
				end
			end
		end
	end

	// receiver: random stalls, or a long hold-off when requested
	always @(negedge clk) begin
		if (rcv_hold_left > 0) begin
			rcv_hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(99) >= rcv_idle_pct;
		end
	end

	// drives one request from a falling edge, returns at the accepting rising edge
	task automatic send_request(request_row_t r);
		relay_state_t p;
		@(negedge clk);
		if ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid     <= 1'b1;
		func         <= r.fn;
		telemetry_ok <= r.tel;
		pv_power_w   <= r.pv;
		site_load_w  <= r.site;
		now_ms       <= r.now;
		relay_index  <= r.idx;
		relay_enable <= r.en;
		mode_auto    <= r.mauto;
		do @(posedge clk); while (!in_ready);
		p = predict_relays(r);
		relay_expect_q.push_back(r.typed ? r.want : p);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			spld_pkg::REG_POWERS:     sh_powers     = val;
			spld_pkg::REG_PRIORITIES: sh_prio       = val[31:0];
			spld_pkg::REG_ACTIVE:     sh_active     = val[3:0];
			spld_pkg::REG_RESERVE:    sh_reserve    = val[15:0];
			spld_pkg::REG_HYSTERESIS: sh_hyst       = val[15:0];
			spld_pkg::REG_MIN_TOGGLE: sh_min_toggle = val[31:0];
			spld_pkg::REG_ACTIVE_LOW: sh_active_low = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering, let every response arrive and the block settle
	task automatic drain_and_settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (relay_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_all_regs(logic [63:0] pw, logic [31:0] pr, logic [3:0] act,
			logic [15:0] res, logic [15:0] hy, logic [31:0] mt, logic al);
		write_reg(spld_pkg::REG_POWERS, pw);
		write_reg(spld_pkg::REG_PRIORITIES, {$urandom, pr});
		write_reg(spld_pkg::REG_ACTIVE, {$urandom, 28'($urandom), act});
		write_reg(spld_pkg::REG_RESERVE, {48'($urandom), res});
		write_reg(spld_pkg::REG_HYSTERESIS, {48'($urandom), hy});
		write_reg(spld_pkg::REG_MIN_TOGGLE, {$urandom, mt});
		write_reg(spld_pkg::REG_ACTIVE_LOW, {63'($urandom), al});
	endtask

	function automatic request_row_t row(logic [1:0] fn, logic tel, logic [15:0] pv,
			logic [15:0] site, logic [31:0] now, logic [1:0] idx, logic en, logic mauto);
		request_row_t r;
		r = '{fn: fn, tel: tel, pv: pv, site: site, now: now, idx: idx, en: en,
			mauto: mauto, typed: 0, want: '0};
		return r;
	endfunction

	function automatic request_row_t typed_row(request_row_t r, relay_state_t w);
		r.typed = 1;
		r.want = w;
		return r;
	endfunction

	// random power, mostly small so loads compete for the surplus
	function automatic logic [15:0] rand_load_w();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'($urandom);
			default: return 16'($urandom_range(1, 4000));
		endcase
	endfunction

	function automatic request_row_t random_request();
		request_row_t r;
		int pick;
		r = row(spld_pkg::FUNC_TICK, 1'b1, 16'($urandom), 16'($urandom), 32'd0,
			2'($urandom), 1'($urandom), 1'($urandom));
		pick = $urandom_range(99);
		if (pick < 68) r.fn = spld_pkg::FUNC_TICK;
		else if (pick < 84) r.fn = spld_pkg::FUNC_MANUAL;
		else if (pick < 96) r.fn = spld_pkg::FUNC_MODE;
		else r.fn = FUNC_UNUSED;
		r.tel = $urandom_range(99) < 90;
		// mode sets lean toward auto so the dispatcher sees real traffic
		if (r.fn == spld_pkg::FUNC_MODE) r.mauto = $urandom_range(99) < 70;
		// site close to pv keeps the surplus near the load ratings
		if ($urandom_range(1)) r.site = (r.pv > 16'd6000) ?
			r.pv - 16'($urandom_range(0, 6000)) : 16'($urandom_range(0, 2000));
		case ($urandom_range(19))
			0: clock_ms = $urandom;
			1: clock_ms = 32'd0;
			default: clock_ms = clock_ms + 32'($urandom_range(0, 300));
		endcase
		r.now = clock_ms;
		return r;
	endfunction

	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		in_valid     = 1'b0;
		func         = spld_pkg::FUNC_TICK;
		telemetry_ok = 1'b0;
		pv_power_w   = '0;
		site_load_w  = '0;
		now_ms       = '0;
		relay_index  = '0;
		relay_enable = 1'b0;
		mode_auto    = 1'b0;
		out_ready    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = spld_pkg::REG_POWERS;
		cfg_data     = '0;
		sh_powers = '0; sh_prio = '0; sh_active = '0; sh_reserve = '0;
		sh_hyst = '0; sh_min_toggle = '0; sh_active_low = 1'b0; sh_auto = 1'b0;
		for (int k = 0; k < NLOADS; k++) begin
			sh_on[k] = 1'b0;
			sh_last[k] = '0;
		end
		clock_ms = $urandom;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// after reset: no active loads, manual mode, every register zero
		directed_rows.push_back(typed_row(row(spld_pkg::FUNC_TICK, 0, 16'hFFFF, 0, 32'd7,
			0, 0, 0), '{4'h0, 4'h0, 1'b1, 1'b0}));
		directed_rows.push_back(typed_row(row(spld_pkg::FUNC_MANUAL, 1, 0, 0, 32'd8,
			2'd3, 1, 0), '{4'h0, 4'h0, 1'b0, 1'b0}));
		directed_rows.push_back(typed_row(row(FUNC_UNUSED, 1, 0, 0, 32'd9, 0, 1, 1),
			'{4'h0, 4'h0, 1'b1, 1'b0}));
		directed_rows.push_back(typed_row(row(spld_pkg::FUNC_MODE, 1, 0, 0, 32'd10,
			0, 0, 1), '{4'h0, 4'h0, 1'b1, 1'b1}));
		directed_rows.push_back(typed_row(row(spld_pkg::FUNC_TICK, 1, 16'hFFFF, 0,
			32'hFFFFFFFF, 0, 0, 0), '{4'h0, 4'h0, 1'b1, 1'b1}));
		directed_rows.push_back(typed_row(row(spld_pkg::FUNC_MODE, 1, 0, 0, 32'd12,
			0, 0, 0), '{4'h0, 4'h0, 1'b1, 1'b0}));
		foreach (directed_rows[i]) send_request(directed_rows[i]);
		directed_rows.delete();
		drain_and_settle();

		// load 3 has no power, loads 1 and 2 tie on priority, relays active low
		write_all_regs(64'h0000_0FA0_07D0_03E8, 32'h00_01_01_02, 4'hF, 16'd100, 16'd50,
			32'd1000, 1'b1);
		write_reg(REG_UNUSED, '1);
		directed_rows.push_back(row(spld_pkg::FUNC_MANUAL, 1, 0, 0, 32'd10, 2'd0, 1, 0));
		directed_rows.push_back(row(spld_pkg::FUNC_MANUAL, 1, 0, 0, 32'd20, 2'd3, 1, 0));
		directed_rows.push_back(row(spld_pkg::FUNC_MANUAL, 1, 0, 0, 32'd30, 2'd1, 1, 0));
		directed_rows.push_back(row(spld_pkg::FUNC_MANUAL, 1, 0, 0, 32'd31, 2'd1, 0, 0));
		directed_rows.push_back(row(spld_pkg::FUNC_TICK, 1, 16'hFFFF, 0, 32'd32, 0, 0, 0));
		directed_rows.push_back(typed_row(row(spld_pkg::FUNC_MODE, 1, 0, 0, 32'd40,
			0, 0, 1), '{4'h0, 4'hF, 1'b1, 1'b1}));
		// inside the minimum toggle time only the never switched load 2 may switch on
		directed_rows.push_back(row(spld_pkg::FUNC_TICK, 1, 16'hFFFF, 0, 32'd50, 0, 0, 0));
		directed_rows.push_back(row(spld_pkg::FUNC_TICK, 1, 16'hFFFF, 0, 32'd5000,
			0, 0, 0));
		// deep deficit, loads just switched stay held
		directed_rows.push_back(row(spld_pkg::FUNC_TICK, 1, 0, 16'hFFFF, 32'd5100,
			0, 0, 0));
		directed_rows.push_back(row(spld_pkg::FUNC_TICK, 1, 0, 16'hFFFF, 32'd7000,
			0, 0, 0));
		// surplus short of one load plus hysteresis
		directed_rows.push_back(row(spld_pkg::FUNC_TICK, 1, 16'd1100, 0, 32'd9000,
			0, 0, 0));
		// time wrapping through zero
		directed_rows.push_back(row(spld_pkg::FUNC_TICK, 1, 16'd3000, 0, 32'hFFFF_FF00,
			0, 0, 0));
		directed_rows.push_back(row(spld_pkg::FUNC_TICK, 1, 0, 16'd500, 32'h0000_0200,
			0, 0, 0));
		directed_rows.push_back(row(spld_pkg::FUNC_TICK, 1, 0, 16'd500, 32'h0000_0000,
			0, 0, 0));
		directed_rows.push_back(row(spld_pkg::FUNC_MANUAL, 1, 0, 0, 32'd3000, 2'd2, 1, 0));
		directed_rows.push_back(typed_row(row(spld_pkg::FUNC_TICK, 0, 16'hFFFF, 0,
			32'hFFFF_0000, 0, 0, 0), '{4'h0, 4'hF, 1'b1, 1'b1}));
		directed_rows.push_back(row(FUNC_UNUSED, 1, 0, 0, 32'd1, 0, 0, 0));
		foreach (directed_rows[i]) send_request(directed_rows[i]);

		// six random segments: receiver stalls most, then sender idles most, then neither
		for (int seg = 0; seg < 6; seg++) begin
			drain_and_settle();
			snd_idle_pct = (seg < 2) ? 37 : (seg < 4) ? 81 : 0;
			rcv_idle_pct = (seg < 2) ? 81 : (seg < 4) ? 37 : 0;
			case (seg)
				1: write_all_regs('1, '1, 4'hF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1);
				3: write_all_regs('0, '0, 4'hF, 16'h0000, 16'h0000, 32'h00000000, 1'b0);
				default: write_all_regs({rand_load_w(), rand_load_w(), rand_load_w(),
					rand_load_w()}, 32'($urandom) & 32'h03030303, 4'($urandom),
					16'($urandom_range(0, 2000)), 16'($urandom_range(0, 1000)),
					32'($urandom_range(0, 200)), 1'($urandom));
			endcase
			// start each segment in auto mode so ticks reach the dispatcher
			send_request(row(spld_pkg::FUNC_MODE, 1, 0, 0, clock_ms, 0, 0, 1));
			for (int n = 0; n < 125; n++) begin
				// long receiver hold-off while requests keep coming
				if (seg == 4 && n == 20) rcv_hold_left = 300;
				send_request(random_request());
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (relay_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/spld_pkg.sv
src/surplus_power_load_dispatcher_core.sv
sim/surplus_power_load_dispatcher_core_tb.sv
